// File: rtl/slr_pkg.sv
// Shared types and constants for the string left-rotate block.
// Used by slr_ctrl, slr_dp and string_left_rotate; no dependencies.
package slr_pkg;

    localparam int CHAR_W = 8;
    localparam int AMT_W  = 31;
    localparam int STEP_W = $clog2(AMT_W);
    // slave tdata: char_in then rotate_amount, padded to whole bytes
    localparam int S_TDATA_W = ((CHAR_W + AMT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        S_LOAD,
        S_MOD,
        S_READ,
        S_SHOW
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // input transaction taken
        logic load_last; // ... and it ends the string
        logic div_step;  // one remainder step
        logic rd;        // read store at current index
        logic adv;       // output transaction taken
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;  // final remainder step is this cycle
        logic out_last;  // character on the output ends the string
    } t_sts;

endpackage

// File: rtl/string_left_rotate.sv
// Top level of the string left-rotate block.
// Instantiates slr_ctrl and slr_dp; depends on slr_pkg.
//
// Characters stream in one per transaction, one per cycle, into a store of
// MAX_LEN entries; characters beyond MAX_LEN are dropped and flag overflow on
// every output of that string. The transaction with tlast carries the rotate
// amount. The block then reduces the amount modulo the stored length L
// (a bit-serial remainder unit, one amount bit per cycle), and emits the
// rotated string with one store read and one output transaction per
// character. No new string is accepted until the last output character
// has been taken.
module string_left_rotate #(
    parameter int MAX_LEN = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave: [7:0] char_in, [38:8] rotate_amount, [39] zero
    input  logic [slr_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tlast,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // master: [7:0] char_out
    output logic [slr_pkg::CHAR_W-1:0]    o_m_tdata,
    output logic                          o_m_tlast,
    // master: [0] overflow
    output logic                          o_m_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready
);

    slr_pkg::t_cmd cmd;
    slr_pkg::t_sts sts;

    slr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    slr_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_char     (i_s_tdata[slr_pkg::CHAR_W-1:0]),
        .i_amount   (i_s_tdata[slr_pkg::CHAR_W +: slr_pkg::AMT_W]),
        .o_sts      (sts),
        .o_char     (o_m_tdata),
        .o_overflow (o_m_tuser)
    );

    assign o_m_tlast = sts.out_last;

endmodule

// File: rtl/slr_ctrl.sv
// Controller for the string left-rotate block: load, modulo, emit sequence.
// Depends on slr_pkg.
module slr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    input  logic          i_m_tready,
    input  slr_pkg::t_sts i_sts,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    output slr_pkg::t_cmd o_cmd
);

    slr_pkg::t_state r_state;
    slr_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slr_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slr_pkg::S_LOAD: begin
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = slr_pkg::S_MOD;
                end
            end
            slr_pkg::S_MOD: begin
                if (i_sts.div_done) begin
                    n_state = slr_pkg::S_READ;
                end
            end
            slr_pkg::S_READ: begin
                n_state = slr_pkg::S_SHOW;
            end
            slr_pkg::S_SHOW: begin
                if (i_m_tready) begin
                    n_state = i_sts.out_last ? slr_pkg::S_LOAD : slr_pkg::S_READ;
                end
            end
            default: begin
                n_state = slr_pkg::S_LOAD;
            end
        endcase
    end

    // outputs and commands
    always_comb begin
        o_s_tready      = 1'b0;
        o_m_tvalid      = 1'b0;
        o_cmd           = '0;
        case (r_state)
            slr_pkg::S_LOAD: begin
                o_s_tready      = 1'b1;
                o_cmd.load      = i_s_tvalid;
                o_cmd.load_last = i_s_tvalid && i_s_tlast;
            end
            slr_pkg::S_MOD: begin
                o_cmd.div_step = 1'b1;
            end
            slr_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
            end
            slr_pkg::S_SHOW: begin
                o_m_tvalid = 1'b1;
                o_cmd.adv  = i_m_tready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/slr_dp.sv
// Datapath for the string left-rotate block: character store, fill count,
// bit-serial remainder unit and output index. Depends on slr_pkg.
module slr_dp #(
    parameter int MAX_LEN = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  slr_pkg::t_cmd              i_cmd,
    input  logic [slr_pkg::CHAR_W-1:0] i_char,
    input  logic [slr_pkg::AMT_W-1:0]  i_amount,
    output slr_pkg::t_sts              o_sts,
    output logic [slr_pkg::CHAR_W-1:0] o_char,
    output logic                       o_overflow
);

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int CNT_W  = ADDR_W + 1;

    logic [slr_pkg::CHAR_W-1:0] r_mem [MAX_LEN];
    logic [slr_pkg::CHAR_W-1:0] r_rd_data;
    logic [CNT_W-1:0]           r_fill;
    logic                       r_ovf;
    logic [slr_pkg::AMT_W-1:0]  r_amt;
    logic [slr_pkg::STEP_W-1:0] r_step;
    logic [ADDR_W-1:0]          r_idx;
    logic [CNT_W-1:0]           r_k;
    logic                       r_out_last;

    logic                       full;
    logic [CNT_W-1:0]           rem_sh;
    logic [ADDR_W-1:0]          n_rem;
    logic [CNT_W-1:0]           idx_inc;

    assign full = (r_fill == CNT_W'(MAX_LEN));

    // one restoring remainder step: shift in next amount bit, subtract length
    always_comb begin
        rem_sh = {r_idx, r_amt[slr_pkg::AMT_W-1]};
        if (rem_sh >= r_fill) begin
            n_rem = ADDR_W'(rem_sh - r_fill);
        end else begin
            n_rem = ADDR_W'(rem_sh);
        end
    end

    assign idx_inc = CNT_W'(r_idx) + CNT_W'(1);

    // character store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            r_mem[r_fill[ADDR_W-1:0]] <= i_char;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // fill count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.adv && r_out_last) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.load) begin
            if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_fill <= r_fill + CNT_W'(1);
            end
        end
    end

    // remainder unit, then output index walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_last) begin
            r_amt  <= i_amount;
            r_step <= '0;
            r_idx  <= '0;
            r_k    <= '0;
        end else if (i_cmd.div_step) begin
            r_amt  <= {r_amt[slr_pkg::AMT_W-2:0], 1'b0};
            r_step <= r_step + slr_pkg::STEP_W'(1);
            r_idx  <= n_rem;
        end else if (i_cmd.adv) begin
            r_idx <= (idx_inc == r_fill) ? '0 : idx_inc[ADDR_W-1:0];
            r_k   <= r_k + CNT_W'(1);
        end
    end

    // last marker for the character being read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_out_last <= ((r_k + CNT_W'(1)) == r_fill);
        end
    end

    assign o_sts.div_done = (r_step == slr_pkg::STEP_W'(slr_pkg::AMT_W - 1));
    assign o_sts.out_last = r_out_last;
    assign o_char         = r_rd_data;
    assign o_overflow     = r_ovf;

endmodule

// File: dv/tb_top.sv
// Testbench for string_left_rotate: streams strings with rotate amounts into the
// slave port and checks each rotated character against an in-bench predictor.
// Depends on slr_pkg and the string_left_rotate RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_LEN  = 64;
    localparam int PAD_W    = slr_pkg::S_TDATA_W - slr_pkg::CHAR_W - slr_pkg::AMT_W;
    localparam int DRAIN    = 4 * MAX_LEN;
    localparam logic [slr_pkg::AMT_W-1:0] AMT_MAX = '1;

    // one input character with the pacing that applies while it is sent
    typedef struct {
        logic [slr_pkg::CHAR_W-1:0] ch;
        logic                       last;
        logic [slr_pkg::AMT_W-1:0]  amount;
        int                         send_idle;
        int                         recv_stall;
        bit                         hold;
    } t_char_item;

    // one expected output character
    typedef struct {
        logic [slr_pkg::CHAR_W-1:0] ch;
        logic                       last;
        logic                       ovf;
    } t_rot_char;

    logic                          i_clk;
    logic                          i_rst_n    = 1'b0;
    logic [slr_pkg::S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                          i_s_tlast  = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [slr_pkg::CHAR_W-1:0]    o_m_tdata;
    logic                          o_m_tlast;
    logic                          o_m_tuser;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;

    t_char_item pending_chars[$];
    t_rot_char  rotated_q[$];
    t_char_item cur_item;

    // predictor state
    logic [slr_pkg::CHAR_W-1:0] char_mem [MAX_LEN];
    int                         fill_cnt  = 0;
    bit                         drop_seen = 1'b0;

    // pacing used while queueing items, and by the receiver
    int ph_send   = 0;
    int ph_recv   = 0;
    bit hold_next = 1'b0;
    int stall_pct = 0;
    int err_cnt   = 0;

    string_left_rotate #(
        .MAX_LEN(MAX_LEN)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast),
        .o_m_tuser (o_m_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, int got, int want);
        if (err_cnt < 100)
            $display("mismatch @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        err_cnt++;
    endtask

    // store one accepted character; on the last one, queue the rotated string
    function automatic void predict_rotation(t_char_item it);
        int unsigned len;
        int unsigned shift;
        int unsigned idx;
        t_rot_char   rc;
        if (fill_cnt < MAX_LEN) begin
            char_mem[fill_cnt] = it.ch;
            fill_cnt++;
        end else begin
            drop_seen = 1'b1;
        end
        if (!it.last)
            return;
        len   = fill_cnt;
        shift = it.amount % len;
        for (int unsigned k = 0; k < len; k++) begin
            idx = shift + k;
            if (idx >= len)
                idx -= len;
            rc.ch   = char_mem[idx];
            rc.last = (k == len - 1);
            rc.ovf  = drop_seen;
            rotated_q.push_back(rc);
        end
        fill_cnt  = 0;
        drop_seen = 1'b0;
    endfunction

    function automatic void add_char(logic [slr_pkg::CHAR_W-1:0] ch, logic last,
                                     logic [slr_pkg::AMT_W-1:0] amount);
        t_char_item it;
        it.ch         = ch;
        it.last       = last;
        it.amount     = amount;
        it.send_idle  = ph_send;
        it.recv_stall = ph_recv;
        it.hold       = hold_next;
        hold_next     = 1'b0;
        pending_chars.push_back(it);
    endfunction

    function automatic void add_text(string s, logic [slr_pkg::AMT_W-1:0] amount);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1, amount);
    endfunction

    // random characters; the amount on the last one is random or hits zero, multiples,
    // small values and values near the top of the range
    function automatic void add_random_string(int len);
        int                        eff;
        logic [slr_pkg::AMT_W-1:0] amt;
        eff = (len > MAX_LEN) ? MAX_LEN : len;
        case ($urandom_range(3))
            0: amt = slr_pkg::AMT_W'($urandom);
            1: amt = slr_pkg::AMT_W'($urandom_range(2 * eff));
            2: amt = slr_pkg::AMT_W'(eff * $urandom_range(1000));
            default: amt = AMT_MAX - slr_pkg::AMT_W'($urandom_range(eff));
        endcase
        for (int i = 0; i < len; i++)
            add_char(slr_pkg::CHAR_W'($urandom_range(1, 255)), i == len - 1,
                     (i == len - 1) ? amt : slr_pkg::AMT_W'($urandom));
    endfunction

    // driver: offers the next queued character, holds it until the transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                predict_rotation(cur_item);
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_chars.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                end else if (pending_chars[0].hold && rotated_q.size() != 0) begin
                    i_s_tvalid <= 1'b0;
                end else if ($urandom_range(99) < pending_chars[0].send_idle) begin
                    i_s_tvalid <= 1'b0;
                end else begin
                    cur_item   = pending_chars.pop_front();
                    stall_pct  = cur_item.recv_stall;
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {{PAD_W{1'b0}}, cur_item.amount, cur_item.ch};
                    i_s_tlast  <= cur_item.last;
                end
            end
        end
    end

    // monitor: checks each output transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_rot_char want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (rotated_q.size() == 0) begin
                    report_mismatch("unexpected char", o_m_tdata, 0);
                end else begin
                    want = rotated_q.pop_front();
                    if (o_m_tdata !== want.ch)
                        report_mismatch("char_out", o_m_tdata, want.ch);
                    if (o_m_tlast !== want.last)
                        report_mismatch("last_out", o_m_tlast, want.last);
                    if (o_m_tuser !== want.ovf)
                        report_mismatch("overflow", o_m_tuser, want.ovf);
                end
            end
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : stimulus
        int phase_items;
        int len;

        // directed: single chars, zero and full-range amounts, multiples, NUL
        add_text("A", slr_pkg::AMT_W'(0));
        add_char(8'hFF, 1'b1, AMT_MAX);
        add_text("ab", slr_pkg::AMT_W'(1));
        add_text("abcd", slr_pkg::AMT_W'(0));
        add_text("wxyz", slr_pkg::AMT_W'(8));
        add_text("1234", AMT_MAX);
        add_char(8'h00, 1'b0, AMT_MAX);
        add_char(8'hFF, 1'b0, slr_pkg::AMT_W'(0));
        add_char(8'h55, 1'b0, AMT_MAX);
        add_char(8'hAA, 1'b0, slr_pkg::AMT_W'(0));
        add_char(8'h01, 1'b1, 31'h5555_5555);

        // random phases: each starts once the previous results are all out
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin ph_send = 0;  ph_recv = 0;  end
                1: begin ph_send = 77; ph_recv = 0;  end
                2: begin ph_send = 0;  ph_recv = 77; end
                default: begin ph_send = 27; ph_recv = 27; end
            endcase
            hold_next   = 1'b1;
            phase_items = 0;
            while (phase_items < ((p % 2) ? 6 : 20)) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 24)
                                               : $urandom_range(1, 8);
                add_random_string(len);
                phase_items += len;
            end
            // exactly full store, then a string that overflows it
            if (p == 1)
                add_random_string(MAX_LEN);
            if (p == 3)
                add_random_string(MAX_LEN + 2);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (rotated_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (err_cnt == 0)
            $display("** string_left_rotate: PASSED **");
        else
            $display("** string_left_rotate: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #(2_000_000);
        $display("** string_left_rotate: FAILED **");
        $finish;
    end

endmodule
